@@ sv/rgbe_pkg.sv @@
// Package: shared widths, register indexes, pipeline types and the channel arithmetic.
`timescale 1ns / 1ps
`default_nettype none
package rgbe_pkg;

  localparam int CHAN_W       = 8;
  localparam int PIXEL_W      = 3 * CHAN_W;
  localparam int COL_W        = 11;
  localparam int ROW_W        = 12;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RST  = 12'd1920;
  localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MIN       = 13'd2;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MAX       = 13'd4096;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [PIXEL_W-1:0] pixel_t;

  // One pixel that has read its column of the line store and waits for the data.
  typedef struct packed {
    logic             emit;
    pixel_t           ul;
    pixel_t           ll;
    pixel_t           cur;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } win_t;

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Half the sum of the two horizontal differences of one channel, truncated.
  function automatic chan_t half_sum(input chan_t ul, input chan_t ur,
                                     input chan_t ll, input chan_t lr);
    logic [CHAN_W:0] s;
    s = {1'b0, abs_diff(ul, ur)} + {1'b0, abs_diff(ll, lr)};
    half_sum = s[CHAN_W:1];
  endfunction

endpackage
`default_nettype wire

@@ sv/rgbe_pix_if.sv @@
// Interface: input pixel channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface rgbe_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;

  modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                  input ready);
  modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                output ready);
endinterface
`default_nettype wire

@@ sv/rgbe_edge_if.sv @@
// Interface: result channel carrying the edge values and window position.
`timescale 1ns / 1ps
`default_nettype none
interface rgbe_edge_if;
  logic        valid;
  logic        ready;
  logic [7:0]  edge_red;
  logic [7:0]  edge_green;
  logic [7:0]  edge_blue;
  logic [10:0] out_column;
  logic [11:0] out_row;

  modport source (output valid, output edge_red, output edge_green, output edge_blue,
                  output out_column, output out_row, input ready);
  modport sink (input valid, input edge_red, input edge_green, input edge_blue,
                input out_column, input out_row, output ready);
endinterface
`default_nettype wire

@@ sv/rgbe_ram.sv @@
// Generic simple dual-port RAM with registered, read-first read port.
`timescale 1ns / 1ps
`default_nettype none
module rgbe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read and a write to the same entry in one cycle return the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

@@ sv/rgb_2x2_horizontal_edge_stream.sv @@
// Top level: streaming 2x2 horizontal-gradient edge detector for RGB pixels.
//
//   channel  | dir | handshake          | beat contents
//   in_pix   | in  | valid/ready        | pixel_red, pixel_green, pixel_blue
//   out_edge | out | valid/ready        | edge_red/green/blue, out_column, out_row
//   cfg_*    | in  | write enable only  | cfg_index, cfg_wdata (width, height)
//
// One pixel is taken per clock unless the output stalls. Each pixel reads and writes
// its column of the line store in the cycle it is accepted; the read data arrives in
// the next cycle, when the result is formed; it is registered when the stage advances.
// Reset clears the counters and left pixels and loads the default frame size; the
// line store needs no clearing. A stalled output holds one result and one behind it.
`timescale 1ns / 1ps
`default_nettype none
module rgb_2x2_horizontal_edge_stream #(
  parameter int MAX_LINE_WIDTH = 2048
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rgbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rgbe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  rgbe_pix_if.sink                              in_pix,
  rgbe_edge_if.source                           out_edge
);
  import rgbe_pkg::*;

  localparam int AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int XW = ((AW > COL_W) ? AW : COL_W) + 1;
  localparam int CW = ((XW > WIDTH_REG_W) ? XW : WIDTH_REG_W) + 2;
  localparam logic [XW-1:0] COL_LIM   = XW'(MAX_LINE_WIDTH - 1);
  localparam logic [CW-1:0] WIDTH_MIN = CW'(2);
  localparam logic [CW-1:0] WIDTH_MAX = CW'(MAX_LINE_WIDTH);

  // Configuration.
  logic [WIDTH_REG_W-1:0]  frame_width_r,  frame_width_nxt;
  logic [HEIGHT_REG_W-1:0] frame_height_r, frame_height_nxt;

  // Raster position and left-hand pixel of the current row.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  pixel_t           left_cur_r, left_cur_nxt;
  logic             rd_seen_r, rd_seen_nxt;

  // Window stage and output register.
  logic  s1_v_r, s1_v_nxt;
  win_t  s1_r, s1_nxt;
  logic  out_v_r, out_v_nxt;
  chan_t edge_red_r, edge_green_r, edge_blue_r;
  chan_t edge_red_nxt, edge_green_nxt, edge_blue_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;

  logic              accept, s1_adv, out_load;
  pixel_t            cur, above, above_prev;
  logic [XW-1:0]     col_x, col_c, col_dec;
  logic [CW-1:0]     fw_x, width_eff, col_inc;
  logic [HEIGHT_REG_W-1:0] height_eff, row_inc;
  logic              col_wrap, row_wrap, emit;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata[WIDTH_REG_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective limits saturate out-of-range settings.
  always_comb begin
    fw_x = CW'(frame_width_r);
    if (fw_x < WIDTH_MIN)      width_eff = WIDTH_MIN;
    else if (fw_x > WIDTH_MAX) width_eff = WIDTH_MAX;
    else                       width_eff = fw_x;
    if (frame_height_r < HEIGHT_MIN)      height_eff = HEIGHT_MIN;
    else if (frame_height_r > HEIGHT_MAX) height_eff = HEIGHT_MAX;
    else                                  height_eff = frame_height_r;
  end

  assign accept = in_pix.valid && in_pix.ready;
  assign cur    = {in_pix.pixel_red, in_pix.pixel_green, in_pix.pixel_blue};

  always_comb begin
    col_x    = XW'(col_r);
    col_c    = (col_x > COL_LIM) ? COL_LIM : col_x;
    col_dec  = col_c - XW'(1);
    col_inc  = CW'(col_c) + CW'(1);
    col_wrap = col_inc >= width_eff;
    row_inc  = HEIGHT_REG_W'(row_r) + HEIGHT_REG_W'(1);
    row_wrap = row_inc >= height_eff;
    emit     = (col_c != '0) && (row_r != '0);
  end

  // The RAM output holds the upper pixel read by the most recent beat, which is the
  // upper-left pixel of the next window.
  assign above_prev = rd_seen_r ? above : '0;

  rgbe_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (col_c[AW-1:0]),
    .wdata (cur),
    .re    (accept),
    .raddr (col_c[AW-1:0]),
    .rdata (above)
  );

  assign s1_adv        = !s1_r.emit || !out_v_r || out_edge.ready;
  assign in_pix.ready  = !s1_v_r || s1_adv;
  assign out_load      = s1_v_r && s1_r.emit && s1_adv;

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    left_cur_nxt = left_cur_r;
    rd_seen_nxt  = rd_seen_r;
    s1_nxt       = s1_r;
    if (accept) begin
      left_cur_nxt = cur;
      rd_seen_nxt  = 1'b1;
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
      s1_nxt.emit = emit;
      s1_nxt.ul   = above_prev;
      s1_nxt.ll   = left_cur_r;
      s1_nxt.cur  = cur;
      s1_nxt.col  = col_dec[COL_W-1:0];
      s1_nxt.row  = row_r - ROW_W'(1);
    end

    if (accept)      s1_v_nxt = 1'b1;
    else if (s1_adv) s1_v_nxt = 1'b0;
    else             s1_v_nxt = s1_v_r;

    if (out_load)            out_v_nxt = 1'b1;
    else if (out_edge.ready) out_v_nxt = 1'b0;
    else                     out_v_nxt = out_v_r;

    edge_red_nxt   = half_sum(s1_r.ul[23:16], above[23:16], s1_r.ll[23:16], s1_r.cur[23:16]);
    edge_green_nxt = half_sum(s1_r.ul[15:8],  above[15:8],  s1_r.ll[15:8],  s1_r.cur[15:8]);
    edge_blue_nxt  = half_sum(s1_r.ul[7:0],   above[7:0],   s1_r.ll[7:0],   s1_r.cur[7:0]);
    out_col_nxt    = s1_r.col;
    out_row_nxt    = s1_r.row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
      left_cur_r     <= '0;
      rd_seen_r      <= 1'b0;
      s1_v_r         <= 1'b0;
      s1_r           <= '0;
      out_v_r        <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      left_cur_r     <= left_cur_nxt;
      rd_seen_r      <= rd_seen_nxt;
      s1_v_r         <= s1_v_nxt;
      s1_r           <= s1_nxt;
      out_v_r        <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      edge_red_r   <= edge_red_nxt;
      edge_green_r <= edge_green_nxt;
      edge_blue_r  <= edge_blue_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
    end
  end

  assign out_edge.valid      = out_v_r;
  assign out_edge.edge_red   = edge_red_r;
  assign out_edge.edge_green = edge_green_r;
  assign out_edge.edge_blue  = edge_blue_r;
  assign out_edge.out_column = out_col_r;
  assign out_edge.out_row    = out_row_r;
endmodule
`default_nettype wire

@@ bench/tb_rgb_2x2_horizontal_edge_stream.sv @@
// Testbench for the RGB 2x2 horizontal edge stream: a line-buffer model predicts every edge beat.
`timescale 1ns / 1ps

import rgbe_pkg::*;

localparam int LINE_DEPTH = 2048;
localparam int ROW_LIMIT  = 4096;

typedef struct packed {
  chan_t            red;
  chan_t            green;
  chan_t            blue;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
} edge_beat_t;

class edge_gradient_model;
  pixel_t                  line_store [LINE_DEPTH];
  pixel_t                  left_lower;
  pixel_t                  left_upper;
  int                      col_cnt;
  int                      row_cnt;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  edge_beat_t              pending_edges [$];
  int                      mismatches;
  int                      edges_checked;
  int                      pixels_seen;

  function void clear();
    left_lower = '0;
    left_upper = '0;
    col_cnt    = 0;
    row_cnt    = 0;
    width_reg  = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    pending_edges.delete();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_FRAME_WIDTH) begin
      width_reg = data[WIDTH_REG_W-1:0];
    end else begin
      height_reg = data;
    end
  endfunction

  function int eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return int'(width_reg);
  endfunction

  function int eff_height();
    if (height_reg < 2) return 2;
    if (height_reg > ROW_LIMIT) return ROW_LIMIT;
    return int'(height_reg);
  endfunction

  function chan_t half_gradient(int ul, int ur, int ll, int lr);
    int dx_upper;
    int dx_lower;
    dx_upper = (ul > ur) ? ul - ur : ur - ul;
    dx_lower = (ll > lr) ? ll - lr : lr - ll;
    return chan_t'((dx_upper + dx_lower) / 2);
  endfunction

  // The arriving pixel closes the window whose upper-left corner is one column left
  // and one row up; the store entry it replaces becomes the next upper-left pixel.
  function void note_pixel(pixel_t px);
    pixel_t     above;
    edge_beat_t beat;
    above = line_store[col_cnt];
    if (col_cnt >= 1 && row_cnt >= 1) begin
      beat.red    = half_gradient(left_upper[23:16], above[23:16], left_lower[23:16], px[23:16]);
      beat.green  = half_gradient(left_upper[15:8], above[15:8], left_lower[15:8], px[15:8]);
      beat.blue   = half_gradient(left_upper[7:0], above[7:0], left_lower[7:0], px[7:0]);
      beat.column = COL_W'(col_cnt - 1);
      beat.row    = ROW_W'(row_cnt - 1);
      pending_edges.push_back(beat);
    end
    left_upper           = above;
    line_store[col_cnt]  = px;
    left_lower           = px;
    if (col_cnt + 1 >= eff_width()) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= eff_height()) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    pixels_seen++;
  endfunction

  function void compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  function void check_edge(edge_beat_t got);
    edge_beat_t want;
    if (pending_edges.size() == 0) begin
      mismatches++;
      $error("result beat at column %0d row %0d with nothing expected", got.column, got.row);
      return;
    end
    want = pending_edges.pop_front();
    compare_field("edge_red", 16'(want.red), 16'(got.red));
    compare_field("edge_green", 16'(want.green), 16'(got.green));
    compare_field("edge_blue", 16'(want.blue), 16'(got.blue));
    compare_field("out_column", 16'(want.column), 16'(got.column));
    compare_field("out_row", 16'(want.row), 16'(got.row));
    edges_checked++;
  endfunction
endclass

module tb_rgb_2x2_horizontal_edge_stream;
  localparam int DRAIN_CYCLES  = 8;
  localparam int IDLE_LIMIT    = 3000;
  localparam int RANDOM_PIXELS = 1100;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rgbe_pix_if  pix_if ();
  rgbe_edge_if edge_if ();

  rgb_2x2_horizontal_edge_stream u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pix    (pix_if),
    .out_edge  (edge_if)
  );

  edge_gradient_model model;
  bit                 send_idling;
  bit                 recv_idling;
  int                 stall_left;
  int                 idle_cycles;
  int                 settings_used;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly back-to-back, some short gaps and the odd long one.
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = int'($urandom_range(99));
    if (r < 60) return 0;
    if (r < 90) return int'($urandom_range(3, 1));
    if (r < 98) return int'($urandom_range(10, 4));
    return int'($urandom_range(60, 20));
  endfunction

  function automatic chan_t rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  function automatic int pick_width();
    int r;
    r = int'($urandom_range(99));
    if (r < 85) return int'($urandom_range(24, 2));
    if (r < 92) return int'($urandom_range(1, 0));
    return int'($urandom_range(80, 25));
  endfunction

  // Result side: random back-pressure, and every accepted beat goes to the model.
  always @(posedge clk) begin
    if (rst_n && edge_if.valid && edge_if.ready)
      model.check_edge({edge_if.edge_red, edge_if.edge_green, edge_if.edge_blue,
                        edge_if.out_column, edge_if.out_row});
    if (stall_left > 0) begin
      edge_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      edge_if.ready <= 1'b1;
      if (recv_idling && $urandom_range(99) < 20) stall_left = pick_gap(1'b1);
    end
  end

  always @(posedge clk) begin
    if ((pix_if.valid && pix_if.ready) || (edge_if.valid && edge_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_pixel(pixel_t px);
    int gap;
    gap = pick_gap(send_idling);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_red   <= px[23:16];
    pix_if.pixel_green <= px[15:8];
    pix_if.pixel_blue  <= px[7:0];
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    model.note_pixel(px);
  endtask

  task automatic wait_for_results();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (model.pending_edges.size() != 0) @(posedge clk);
    // Pixels in the first row or column leave no beat, so give them time to clear.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_frame(int wd, int ht);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= CFG_DATA_W'(wd);
    @(posedge clk);
    model.write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(wd));
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(ht);
    @(posedge clk);
    model.write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(ht));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic finish_frame();
    while (model.col_cnt != 0 || model.row_cnt != 0) send_pixel(rand_pixel());
  endtask

  task automatic send_frames(int count);
    repeat (count) send_pixel(rand_pixel());
    finish_frame();
  endtask

  initial begin : stimulus
    pixel_t directed_px [18];
    int random_start;
    int n;

    // Three frames of 3x2: full swings, mixed channels with odd sums, and flat areas.
    directed_px = '{
      24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
      24'hFF00FF, 24'h00FF00, 24'h7F8001, 24'h00FF80, 24'hFF0001, 24'h80FE7F,
      24'h123456, 24'h123456, 24'hFEDCBA, 24'h123456, 24'h123456, 24'hFEDCBA
    };
    model = new();
    model.clear();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    pix_if.valid       <= 1'b0;
    pix_if.pixel_red   <= '0;
    pix_if.pixel_green <= '0;
    pix_if.pixel_blue  <= '0;
    send_idling        = 1'b0;
    recv_idling        = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    model.clear();

    // A few pixels at the reset width, then narrowing mid-row: the column count is
    // already past the new width and wraps.
    repeat (10) send_pixel(rand_pixel());
    wait_for_results();
    program_frame(3, 2);
    finish_frame();
    foreach (directed_px[i]) send_pixel(directed_px[i]);

    // Bit 12 of the write data is beyond the width register and must be dropped.
    wait_for_results();
    program_frame(13'h1003, 1);
    send_frames(30);
    wait_for_results();
    program_frame(0, 0);
    send_frames(12);

    // Shrink both limits mid-frame with the row count past the new height.
    send_idling = 1'b1;
    wait_for_results();
    program_frame(5, 8);
    repeat (27) send_pixel(rand_pixel());
    wait_for_results();
    program_frame(4, 3);
    finish_frame();

    // Oversized limits saturate, so a long first row does not wrap early.
    wait_for_results();
    program_frame(4095, 8191);
    repeat (40) send_pixel(rand_pixel());
    wait_for_results();
    program_frame(2, 2);
    finish_frame();

    random_start = model.pixels_seen;
    while (model.pixels_seen - random_start < RANDOM_PIXELS) begin
      send_idling = ($urandom_range(3) != 0);
      recv_idling = ($urandom_range(3) != 0);
      wait_for_results();
      program_frame(pick_width(), int'($urandom_range(12)));
      n = int'($urandom_range(80, 10));
      repeat (n) send_pixel(rand_pixel());
      if ($urandom_range(3) == 0) begin
        // A narrower line is always covered by the row above, so only shrink mid-frame.
        wait_for_results();
        program_frame(int'($urandom_range(model.eff_width())), int'($urandom_range(12)));
        repeat (int'($urandom_range(30))) send_pixel(rand_pixel());
      end
      finish_frame();
    end

    wait_for_results();
    $display("Run covered %0d pixels and %0d edge beats over %0d frame settings,",
             model.pixels_seen, model.edges_checked, settings_used);
    $display("with out-of-range sizes, mid-frame writes and random stalls on both sides.");
    if (model.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/rgbe_pkg.sv
sv/rgbe_pix_if.sv
sv/rgbe_edge_if.sv
sv/rgbe_ram.sv
sv/rgb_2x2_horizontal_edge_stream.sv
bench/tb_rgb_2x2_horizontal_edge_stream.sv
